### rtl/core/char_lcd_nibble_writer_top_assert.svh
// Assertion macros shared by the display writer RTL.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef CHAR_LCD_NIBBLE_WRITER_TOP_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITER_TOP_ASSERT_SVH

// Same-cycle implication.
`define CHLCD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CHLCD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/chlcd_pkg.sv
// ----------------------------------------------------------------------------
// chlcd_pkg
// Types, constants and result-building functions for the display writer.
// ----------------------------------------------------------------------------
package chlcd_pkg;

    localparam int DISPLAY_LINES = 2;

    localparam int LEN_W   = 6;
    localparam int NWAIT_W = 10;
    localparam int BWAIT_W = 14;
    localparam int COL_W   = 7;
    localparam int STEP_W  = 4;
    localparam int IDX_W   = 2;
    localparam int CDATA_W = 14;
    localparam int WBEF_W  = 16;
    localparam int WAFT_W  = 15;

    // Input request codes
    localparam logic [1:0] CMD_COMMAND = 2'd0;
    localparam logic [1:0] CMD_CHAR    = 2'd1;
    localparam logic [1:0] CMD_INIT    = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_LINE_LENGTH = 2'd0;
    localparam logic [IDX_W-1:0] CFG_NIBBLE_WAIT = 2'd1;
    localparam logic [IDX_W-1:0] CFG_BYTE_WAIT   = 2'd2;

    localparam logic [LEN_W-1:0]   LINE_LENGTH_RST = 6'd16;
    localparam logic [NWAIT_W-1:0] NIBBLE_WAIT_RST = 10'd10;
    localparam logic [BWAIT_W-1:0] BYTE_WAIT_RST   = 14'd100;

    localparam logic [7:0] LINE2_ADDR = 8'hC0;
    localparam logic [7:0] CLEAR_CMD  = 8'h01;
    localparam logic [7:0] HOME_CMD   = 8'h02;
    localparam logic [7:0] FUNC_SET   = 8'h28;
    localparam logic [7:0] DISP_ON    = 8'h0E;

    localparam logic [WBEF_W-1:0] POWERUP_WAIT_US  = 16'd35000;
    localparam logic [WAFT_W-1:0] SLOW_CMD_WAIT_US = 15'd2000;

    typedef enum logic [2:0] {
        MODE_INIT = 3'd0,
        MODE_CMD  = 3'd1,
        MODE_CHAR = 3'd2,
        MODE_WRAP = 3'd3,
        MODE_DROP = 3'd4
    } mode_t;

    typedef struct packed {
        logic [LEN_W-1:0]   line_length;
        logic [NWAIT_W-1:0] nibble_wait_us;
        logic [BWAIT_W-1:0] byte_wait_us;
    } cfg_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] value;
    } plan_t;

    typedef struct packed {
        logic              kind;
        logic              reg_select;
        logic [3:0]        nibble;
        logic [WBEF_W-1:0] wait_before_us;
        logic [WAFT_W-1:0] wait_after_us;
        logic              last;
    } result_t;

    function automatic logic [STEP_W-1:0] result_count(mode_t m);
        logic [STEP_W-1:0] n;
        case (m)
            MODE_INIT: n = 4'd12;
            MODE_CMD:  n = 4'd2;
            MODE_CHAR: n = 4'd2;
            MODE_WRAP: n = 4'd4;
            default:   n = 4'd1;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] init_byte(logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0, 3'd1, 3'd2: b = FUNC_SET;
            3'd3:             b = DISP_ON;
            3'd4:             b = HOME_CMD;
            3'd5:             b = CLEAR_CMD;
            default:          b = FUNC_SET;
        endcase
        return b;
    endfunction

    // One bus transfer for the given step of a planned request
    function automatic result_t make_result(plan_t p, logic [STEP_W-1:0] step, cfg_t c);
        logic [7:0]        b;
        logic              rs;
        logic [WAFT_W-1:0] extra;
        result_t           r;
        r     = '0;
        b     = p.value;
        rs    = 1'b0;
        extra = '0;
        case (p.mode)
            MODE_INIT:
            begin
                b = init_byte(step[3:1]);
                if (b == HOME_CMD || b == CLEAR_CMD)
                begin
                    extra = SLOW_CMD_WAIT_US;
                end
            end
            MODE_CHAR: rs = 1'b1;
            MODE_WRAP:
            begin
                if (!step[1])
                begin
                    b = LINE2_ADDR;
                end
                else
                begin
                    rs = 1'b1;
                end
            end
            default: ;
        endcase
        if (p.mode == MODE_DROP)
        begin
            r.kind = 1'b1;
        end
        else
        begin
            r.reg_select     = rs;
            r.nibble         = step[0] ? b[3:0] : b[7:4];
            r.wait_before_us = (p.mode == MODE_INIT && step == '0) ? POWERUP_WAIT_US : '0;
            r.wait_after_us  = step[0]
                ? (WAFT_W'(c.nibble_wait_us) + WAFT_W'(c.byte_wait_us) + extra)
                : WAFT_W'(c.nibble_wait_us);
        end
        r.last = (step == result_count(p.mode) - 4'd1);
        return r;
    endfunction

endpackage

### rtl/core/chlcd_cfg_regs.sv
// ----------------------------------------------------------------------------
// chlcd_cfg_regs
// Configuration register file: line length and bus wait times.
// ----------------------------------------------------------------------------
module chlcd_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [chlcd_pkg::IDX_W-1:0] cfg_index,
    input  logic [chlcd_pkg::CDATA_W-1:0] cfg_data,
    output chlcd_pkg::cfg_t             cfg
);
    import chlcd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LINE_LENGTH: cfg_next.line_length    = cfg_data[LEN_W-1:0];
                CFG_NIBBLE_WAIT: cfg_next.nibble_wait_us = cfg_data[NWAIT_W-1:0];
                CFG_BYTE_WAIT:   cfg_next.byte_wait_us   = cfg_data[BWAIT_W-1:0];
                default: ;  // unknown index: ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_length    <= LINE_LENGTH_RST;
            cfg_reg.nibble_wait_us <= NIBBLE_WAIT_RST;
            cfg_reg.byte_wait_us   <= BYTE_WAIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/core/chlcd_planner.sv
// ----------------------------------------------------------------------------
// chlcd_planner
// Request register: classifies each request and tracks the column count.
// ----------------------------------------------------------------------------
`include "char_lcd_nibble_writer_top_assert.svh"

module chlcd_planner (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        cmd,
    input  logic [7:0]        value,
    input  chlcd_pkg::cfg_t   cfg,
    input  logic              seq_done,
    output logic              plan_valid,
    output chlcd_pkg::plan_t  plan
);
    import chlcd_pkg::*;

    logic             plan_valid_reg;
    logic             plan_valid_next;
    plan_t            plan_reg;
    plan_t            plan_next;
    logic [COL_W-1:0] column_count_reg;
    logic [COL_W-1:0] column_count_next;
    logic [COL_W-1:0] capacity;
    logic             full;
    logic             wrap;
    logic             accept;

    assign in_stall   = plan_valid_reg && !seq_done;
    assign accept     = in_valid && !in_stall;
    assign plan_valid = plan_valid_reg;
    assign plan       = plan_reg;

    assign capacity = COL_W'(DISPLAY_LINES) * {1'b0, cfg.line_length};
    assign full     = column_count_reg >= capacity;
    assign wrap     = (DISPLAY_LINES == 2) && (column_count_reg == {1'b0, cfg.line_length});

    always_comb
    begin
        plan_valid_next   = plan_valid_reg && !seq_done;
        plan_next         = plan_reg;
        column_count_next = column_count_reg;
        if (accept)
        begin
            plan_valid_next = (cmd != CMD_NONE);
            plan_next.value = value;
            case (cmd)
                CMD_INIT:
                begin
                    plan_next.mode    = MODE_INIT;
                    column_count_next = '0;
                end
                CMD_COMMAND:
                begin
                    plan_next.mode = MODE_CMD;
                    if (value == CLEAR_CMD)
                    begin
                        column_count_next = '0;
                    end
                end
                CMD_CHAR:
                begin
                    if (full)
                    begin
                        plan_next.mode = MODE_DROP;
                    end
                    else
                    begin
                        plan_next.mode    = wrap ? MODE_WRAP : MODE_CHAR;
                        column_count_next = column_count_reg + 7'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plan_valid_reg   <= 1'b0;
            column_count_reg <= '0;
        end
        else
        begin
            plan_valid_reg   <= plan_valid_next;
            column_count_reg <= column_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        plan_reg <= plan_next;
    end

    `CHLCD_ASSERT_NXT(a_init_clears_count, accept && cmd == CMD_INIT, column_count_reg == '0, "init did not clear column count")
    `CHLCD_ASSERT_IMP(a_empty_never_stalls, !plan_valid_reg, !in_stall, "stall while request register empty")
    `CHLCD_ASSERT_NXT(a_busy_plan_holds, plan_valid_reg && !seq_done, plan_valid_reg && $stable(plan_reg), "pending request changed")

endmodule

### rtl/core/chlcd_sequencer.sv
// ----------------------------------------------------------------------------
// chlcd_sequencer
// Steps through the transfers of a request into the result register.
// ----------------------------------------------------------------------------
`include "char_lcd_nibble_writer_top_assert.svh"

module chlcd_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                plan_valid,
    input  chlcd_pkg::plan_t    plan,
    input  chlcd_pkg::cfg_t     cfg,
    output logic                seq_done,
    output logic                out_valid,
    input  logic                out_stall,
    output chlcd_pkg::result_t  result
);
    import chlcd_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           out_reg;
    result_t           res;
    logic              emit;

    assign res      = make_result(plan, step_reg, cfg);
    assign emit     = plan_valid && (!out_valid_reg || !out_stall);
    assign seq_done = emit && res.last;

    assign out_valid = out_valid_reg;
    assign result    = out_reg;

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (emit)
        begin
            out_valid_next = 1'b1;
            step_next      = res.last ? '0 : step_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= res;
        end
    end

    `CHLCD_ASSERT_IMP(a_step_in_range, plan_valid, step_reg < result_count(plan.mode), "step past end of request")
    `CHLCD_ASSERT_IMP(a_drop_is_last, out_valid_reg && out_reg.kind, out_reg.last, "drop report not last")
    `CHLCD_ASSERT_NXT(a_step_rewinds, seq_done, step_reg == '0, "step did not rewind after last transfer")

endmodule

### rtl/core/char_lcd_nibble_writer_top.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_top
// Two-line character display writer for a 4-bit bus.
// ----------------------------------------------------------------------------
// Each request becomes a run of bus transfers, one per cycle on the result
// channel unless it stalls: a command byte or character gives 2 transfers, a
// character that follows a full line one gives 4 (line-two address first),
// initialize gives 12, a character on a full display gives one drop report.
// The sequencer moves one transfer per cycle into the result register while
// the result channel does not stall; the next request is taken in the same
// cycle that the last transfer of the current one is loaded. A request with
// the unused code is taken and gives no transfer. Configuration writes are
// always ready and take effect at the next cycle; write them only while the
// writer is idle.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer_top (
    input  logic                             clk,
    input  logic                             rst_n,
    // request channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       cmd,
    input  logic [7:0]                       value,
    // transfer channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             kind,
    output logic                             reg_select,
    output logic [3:0]                       nibble,
    output logic [chlcd_pkg::WBEF_W-1:0]     wait_before_us,
    output logic [chlcd_pkg::WAFT_W-1:0]     wait_after_us,
    output logic                             last,
    // configuration write
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [chlcd_pkg::IDX_W-1:0]      cfg_index,
    input  logic [chlcd_pkg::CDATA_W-1:0]    cfg_data
);
    import chlcd_pkg::*;

    cfg_t    cfg;
    plan_t   plan;
    logic    plan_valid;
    logic    seq_done;
    result_t result;

    // register file: line length, per-nibble and per-byte waits
    chlcd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // request register; decides wrap/drop against the column count at intake
    chlcd_planner u_planner (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .value      (value),
        .cfg        (cfg),
        .seq_done   (seq_done),
        .plan_valid (plan_valid),
        .plan       (plan)
    );

    // emits one transfer per cycle into the result register unless the result channel stalls
    chlcd_sequencer u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .plan_valid (plan_valid),
        .plan       (plan),
        .cfg        (cfg),
        .seq_done   (seq_done),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result     (result)
    );

    assign kind           = result.kind;
    assign reg_select     = result.reg_select;
    assign nibble         = result.nibble;
    assign wait_before_us = result.wait_before_us;
    assign wait_after_us  = result.wait_after_us;
    assign last           = result.last;

endmodule
